FILE: hdl/sspu_pkg.sv
// ----------------------------------------------------------------------------
// sspu_pkg: shared types and constants
// Status codes, subpacket types and the item passed from front to back.
// ----------------------------------------------------------------------------
package sspu_pkg;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_CORRUPT = 2'd1;
  localparam logic [1:0] ST_DUP     = 2'd2;
  localparam logic [1:0] ST_CRIT    = 2'd3;

  localparam logic [7:0] LEN_TWO_MIN = 8'd192;
  localparam logic [7:0] LEN_FIVE    = 8'd255;
  localparam logic [7:0] SIG_SUBKEY_BINDING = 8'h18;

  // subpacket types, critical bit stripped
  localparam logic [6:0] SP_CREATION = 7'd2;
  localparam logic [6:0] SP_SIG_EXP  = 7'd3;
  localparam logic [6:0] SP_KEY_EXP  = 7'd9;
  localparam logic [6:0] SP_ISSUER   = 7'd16;
  localparam logic [6:0] SP_PRIMARY  = 7'd25;
  localparam logic [6:0] SP_FLAGS    = 7'd27;
  localparam logic [6:0] SP_EMBEDDED = 7'd32;
  localparam logic [6:0] SP_ISS_FP   = 7'd33;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       hashed_area;
    logic       first_of_signature;
    logic       last_of_area;
    logic       area_empty;
  } item_t;

endpackage

FILE: hdl/signature_subpacket_parser_unit.sv
// Result path: an area's final item passes through the queue, then the result
//   register and out_valid load as the parser takes that item.
// Throughput: one byte per cycle, the parser back end handling a byte a cycle
//   while no result is held waiting for out_ready.
// Reset: rst clears the queue, parser state, fields and signature type.
// ----------------------------------------------------------------------------
// signature_subpacket_parser_unit: top level
// Input queue front end and subpacket parser back end.
// ----------------------------------------------------------------------------
module signature_subpacket_parser_unit
  import sspu_pkg::*;
#(
  parameter int LENGTH_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        hashed_area,
  input  logic        first_of_signature,
  input  logic        last_of_area,
  input  logic        area_empty,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [6:0]  found_mask,
  output logic [31:0] creation_time,
  output logic [31:0] signature_expiry,
  output logic [31:0] key_expiry,
  output logic [7:0]  key_flag_bits,
  output logic [63:0] issuer_key_id,
  output logic [2:0]  fingerprint_version,
  output logic [23:0] embedded_offset,
  output logic [23:0] embedded_length,
  output logic        embedded_in_hashed
);

  logic [7:0] signature_type;
  item_t      in_item;
  item_t      q_item;
  logic       q_valid;
  logic       q_ready;

  always_ff @(posedge clk) begin
    if (rst) signature_type <= '0;
    else if (cfg_we) signature_type <= cfg_wdata;
  end

  assign in_item = '{data_byte: data_byte, hashed_area: hashed_area,
                     first_of_signature: first_of_signature,
                     last_of_area: last_of_area, area_empty: area_empty};

  sspu_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_item(in_item), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
  );

  sspu_back #(.LENGTH_BITS(LENGTH_BITS)) u_back (
    .clk(clk), .rst(rst), .sig_type(signature_type),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .found_mask(found_mask), .creation_time(creation_time),
    .signature_expiry(signature_expiry), .key_expiry(key_expiry),
    .key_flag_bits(key_flag_bits), .issuer_key_id(issuer_key_id),
    .fingerprint_version(fingerprint_version),
    .embedded_offset(embedded_offset), .embedded_length(embedded_length),
    .embedded_in_hashed(embedded_in_hashed)
  );

endmodule

FILE: hdl/sspu_front.sv
// ----------------------------------------------------------------------------
// sspu_front: input stage and queue
// Takes input transfers into a two-entry queue feeding the parser back end.
// ----------------------------------------------------------------------------
module sspu_front
  import sspu_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  q_valid,
  input  logic  q_ready,
  output item_t q_item
);

  item_t      entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_item   = entry[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= in_item;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

FILE: hdl/sspu_back.sv
// ----------------------------------------------------------------------------
// sspu_back: subpacket parser
// Decodes lengths and types, extracts fields, gives one result per area.
// ----------------------------------------------------------------------------
module sspu_back
  import sspu_pkg::*;
#(
  parameter int LENGTH_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  sig_type,
  input  logic        q_valid,
  output logic        q_ready,
  input  item_t       q_item,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [6:0]  found_mask,
  output logic [31:0] creation_time,
  output logic [31:0] signature_expiry,
  output logic [31:0] key_expiry,
  output logic [7:0]  key_flag_bits,
  output logic [63:0] issuer_key_id,
  output logic [2:0]  fingerprint_version,
  output logic [23:0] embedded_offset,
  output logic [23:0] embedded_length,
  output logic        embedded_in_hashed
);

  localparam logic [2:0] PH_LEN0 = 3'd0;
  localparam logic [2:0] PH_LEN1 = 3'd1;
  localparam logic [2:0] PH_LEN5 = 3'd2;
  localparam logic [2:0] PH_TYPE = 3'd3;
  localparam logic [2:0] PH_BODY = 3'd4;
  localparam logic [2:0] PH_SKIP = 3'd5;

  localparam int LB = LENGTH_BITS;

  // parser state
  logic [2:0]    phase, phase_next;
  logic [31:0]   len_acc, len_acc_next;
  logic [7:0]    sp_type, sp_type_next;
  logic [LB-1:0] body_idx, body_idx_next;
  logic [LB-1:0] body_len, body_len_next;
  logic [7:0]    body_first, body_first_next;
  logic [LB-1:0] body_start, body_start_next;
  logic [63:0]   vshift, vshift_next;
  logic [LB-1:0] area_pos, area_pos_next;
  // extracted fields
  logic [1:0]    err, err_next;
  logic [6:0]    found, found_next;
  logic [31:0]   time_v, time_v_next;
  logic [31:0]   sexp_v, sexp_v_next;
  logic [31:0]   kexp_v, kexp_v_next;
  logic [7:0]    flags_v, flags_v_next;
  logic [63:0]   kid_v, kid_v_next;
  logic [2:0]    fpv_v, fpv_v_next;
  logic [LB-1:0] emb_off, emb_off_next;
  logic [LB-1:0] emb_len, emb_len_next;
  logic          emb_h, emb_h_next;

  logic take;
  logic emit;
  logic done;

  assign q_ready = !out_valid || out_ready;
  assign take    = q_valid && q_ready;

  always_comb begin
    logic [7:0]    b;
    logic          hs;
    logic          fin;
    logic [LB-1:0] n;
    logic [6:0]    t;
    logic          impl;
    logic [1:0]    e;
    logic          newfp;
    logic          okfp;
    logic          sh;
    logic [LB-1:0] idx1;
    logic [LB:0]   two;

    b     = q_item.data_byte;
    hs    = q_item.hashed_area;
    fin   = 1'b0;
    impl  = 1'b0;
    e     = ST_OK;
    okfp  = 1'b0;
    sh    = 1'b1;
    idx1  = '0;
    two   = '0;
    t     = '0;
    n     = '0;
    newfp = 1'b0;

    phase_next      = phase;
    len_acc_next    = len_acc;
    sp_type_next    = sp_type;
    body_idx_next   = body_idx;
    body_len_next   = body_len;
    body_first_next = body_first;
    body_start_next = body_start;
    vshift_next     = vshift;
    area_pos_next   = area_pos;
    err_next        = err;
    found_next      = found;
    time_v_next     = time_v;
    sexp_v_next     = sexp_v;
    kexp_v_next     = kexp_v;
    flags_v_next    = flags_v;
    kid_v_next      = kid_v;
    fpv_v_next      = fpv_v;
    emb_off_next    = emb_off;
    emb_len_next    = emb_len;
    emb_h_next      = emb_h;

    if (q_item.first_of_signature) begin
      phase_next = PH_LEN0; len_acc_next = '0; sp_type_next = '0;
      body_idx_next = '0; body_len_next = '0; body_first_next = '0;
      body_start_next = '0; vshift_next = '0; area_pos_next = '0;
      err_next = ST_OK; found_next = '0; time_v_next = '0; sexp_v_next = '0;
      kexp_v_next = '0; flags_v_next = '0; kid_v_next = '0; fpv_v_next = '0;
      emb_off_next = '0; emb_len_next = '0; emb_h_next = 1'b0;
    end

    if (!q_item.area_empty) begin
      if (err_next == ST_OK) begin
        case (phase_next)
          PH_LEN0: begin
            if (b < LEN_TWO_MIN) begin
              if (b == 8'd0) begin
                err_next = ST_CORRUPT; phase_next = PH_SKIP;
              end else begin
                body_len_next = LB'(b);
                phase_next = PH_TYPE;
              end
            end else if (b < LEN_FIVE) begin
              len_acc_next = {24'd0, b};
              phase_next = PH_LEN1;
            end else begin
              len_acc_next = '0;
              body_idx_next = '0;
              phase_next = PH_LEN5;
            end
          end
          PH_LEN1: begin
            two = (LB+1)'({len_acc_next[5:0], b}) + (LB+1)'(LEN_TWO_MIN);
            body_len_next = two[LB-1:0];
            phase_next = PH_TYPE;
          end
          PH_LEN5: begin
            len_acc_next = {len_acc_next[23:0], b};
            body_idx_next = body_idx_next + 1'b1;
            if (body_idx_next >= LB'(4)) begin
              if ((LB < 32 && (len_acc_next >> LB) != 32'd0) ||
                  len_acc_next == 32'd0) begin
                err_next = ST_CORRUPT; phase_next = PH_SKIP;
              end else begin
                body_len_next = len_acc_next[LB-1:0];
                phase_next = PH_TYPE;
              end
            end
          end
          PH_TYPE: begin
            sp_type_next = b;
            body_len_next = body_len_next - 1'b1;
            body_idx_next = '0;
            body_first_next = '0;
            vshift_next = '0;
            body_start_next = area_pos_next + 1'b1;
            if (body_len_next == '0) fin = 1'b1;
            else phase_next = PH_BODY;
          end
          PH_BODY: begin
            if (body_idx_next == '0) body_first_next = b;
            if (sp_type_next[6:0] == SP_ISS_FP &&
                (body_first_next == 8'd5 || body_first_next == 8'd6))
              sh = (body_idx_next >= LB'(1)) && (body_idx_next <= LB'(8));
            if (sh) vshift_next = {vshift_next[55:0], b};
            idx1 = body_idx_next + 1'b1;
            body_idx_next = idx1;
            if (idx1 >= body_len_next) fin = 1'b1;
          end
          default: ;
        endcase

        if (fin) begin
          t = sp_type_next[6:0];
          n = body_len_next;
          newfp = (body_first_next == 8'd5) || (body_first_next == 8'd6);
          case (t)
            SP_CREATION: if (hs && n == LB'(4)) begin
              if (found_next[0]) e = ST_DUP;
              else begin
                impl = 1'b1; time_v_next = vshift_next[31:0]; found_next[0] = 1'b1;
              end
            end
            SP_ISSUER: if (n == LB'(8)) begin
              impl = 1'b1;
              if (!found_next[1]) begin
                kid_v_next = vshift_next; found_next[1] = 1'b1;
              end
            end
            SP_ISS_FP: if (n >= LB'(17)) begin
              okfp = (body_first_next == 8'd4 && n == LB'(21)) ||
                     (newfp && n == LB'(33));
              impl = 1'b1;
              if (okfp && !found_next[2]) begin
                fpv_v_next = body_first_next[2:0]; found_next[2] = 1'b1;
              end
              if (okfp && !found_next[1]) begin
                kid_v_next = vshift_next; found_next[1] = 1'b1;
              end
            end
            SP_FLAGS: if (hs) begin
              if (found_next[3]) e = ST_DUP;
              else begin
                impl = 1'b1;
                flags_v_next = (n >= LB'(1)) ? body_first_next : 8'd0;
                found_next[3] = 1'b1;
              end
            end
            SP_KEY_EXP: if (hs && n == LB'(4)) begin
              if (found_next[4]) e = ST_DUP;
              else begin
                impl = 1'b1; kexp_v_next = vshift_next[31:0]; found_next[4] = 1'b1;
              end
            end
            SP_SIG_EXP: if (hs && n == LB'(4)) begin
              if (found_next[5]) e = ST_DUP;
              else begin
                impl = 1'b1; sexp_v_next = vshift_next[31:0]; found_next[5] = 1'b1;
              end
            end
            SP_EMBEDDED: if (sig_type == SIG_SUBKEY_BINDING && n >= LB'(6) &&
                       emb_len_next == '0) begin
              impl = 1'b1;
              emb_off_next = body_start_next;
              emb_len_next = n;
              emb_h_next = hs;
            end
            SP_PRIMARY: if (hs && n == LB'(1)) begin
              impl = 1'b1;
              if (body_first_next != 8'd0) found_next[6] = 1'b1;
            end
            default: ;
          endcase
          if (e == ST_OK && !impl && sp_type_next[7]) e = ST_CRIT;
          if (e != ST_OK) begin
            err_next = e; phase_next = PH_SKIP;
          end else begin
            phase_next = PH_LEN0;
          end
        end
      end
      area_pos_next = area_pos_next + 1'b1;
    end

    done = q_item.area_empty || q_item.last_of_area;
    if (done) begin
      if (err_next == ST_OK && phase_next != PH_LEN0) err_next = ST_CORRUPT;
    end
  end

  assign emit = take && done;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_LEN0; len_acc <= '0; sp_type <= '0; body_idx <= '0;
      body_len <= '0; body_first <= '0; body_start <= '0; vshift <= '0;
      area_pos <= '0; err <= ST_OK; found <= '0; time_v <= '0; sexp_v <= '0;
      kexp_v <= '0; flags_v <= '0; kid_v <= '0; fpv_v <= '0;
      emb_off <= '0; emb_len <= '0; emb_h <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        err <= err_next; found <= found_next; time_v <= time_v_next;
        sexp_v <= sexp_v_next; kexp_v <= kexp_v_next; flags_v <= flags_v_next;
        kid_v <= kid_v_next; fpv_v <= fpv_v_next; emb_off <= emb_off_next;
        emb_len <= emb_len_next; emb_h <= emb_h_next;
        if (done) begin
          // parser restarts for the next area
          phase <= PH_LEN0; len_acc <= '0; sp_type <= '0; body_idx <= '0;
          body_len <= '0; body_first <= '0; body_start <= '0; vshift <= '0;
          area_pos <= '0;
        end else begin
          phase <= phase_next; len_acc <= len_acc_next; sp_type <= sp_type_next;
          body_idx <= body_idx_next; body_len <= body_len_next;
          body_first <= body_first_next; body_start <= body_start_next;
          vshift <= vshift_next; area_pos <= area_pos_next;
        end
      end
      if (emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (emit) begin
      status              <= err_next;
      found_mask          <= found_next;
      creation_time       <= time_v_next;
      signature_expiry    <= sexp_v_next;
      key_expiry          <= kexp_v_next;
      key_flag_bits       <= flags_v_next;
      issuer_key_id       <= kid_v_next;
      fingerprint_version <= fpv_v_next;
      embedded_offset     <= 24'(emb_off_next);
      embedded_length     <= 24'(emb_len_next);
      embedded_in_hashed  <= emb_h_next;
    end
  end

endmodule

FILE: tb/tb_signature_subpacket_parser_unit.sv
// ----------------------------------------------------------------------------
// tb_signature_subpacket_parser_unit: self-checking testbench
// Feeds subpacket areas byte by byte, predicts each end-of-area result from
// its own parser model and checks every result field in order.
// ----------------------------------------------------------------------------
module tb_signature_subpacket_parser_unit;
  import sspu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LB = 24;
  localparam int CYCLE_LIMIT = 200000;

  localparam logic [7:0] CRIT_BIT    = 8'h80;

  localparam logic [6:0] F_TIME = 7'h01, F_ID = 7'h02, F_FP = 7'h04, F_FLAGS = 7'h08;
  localparam logic [6:0] F_KEXP = 7'h10, F_SEXP = 7'h20, F_PRIM = 7'h40;

  typedef enum logic [2:0] {P_LEN0, P_LEN1, P_LEN5, P_TYPE, P_BODY, P_SKIP} phase_e;

  typedef struct {
    logic [1:0]  status;
    logic [6:0]  found;
    logic [31:0] ctime, sexp, kexp;
    logic [7:0]  flags;
    logic [63:0] key_id;
    logic [2:0]  fp_ver;
    logic [23:0] emb_off, emb_len;
    logic        emb_hashed;
  } area_result_t;

  logic clk = 0, rst = 1;
  logic cfg_we = 0;
  logic [7:0] cfg_wdata = 0;
  logic in_valid = 0, in_ready;
  logic [7:0] data_byte = 0;
  logic hashed_area = 0, first_of_signature = 0, last_of_area = 0, area_empty = 0;
  logic out_valid, out_ready = 0;
  logic [1:0] status;
  logic [6:0] found_mask;
  logic [31:0] creation_time, signature_expiry, key_expiry;
  logic [7:0] key_flag_bits;
  logic [63:0] issuer_key_id;
  logic [2:0] fingerprint_version;
  logic [23:0] embedded_offset, embedded_length;
  logic embedded_in_hashed;

  signature_subpacket_parser_unit u_dut (
    .clk, .rst, .cfg_we, .cfg_wdata, .in_valid, .in_ready,
    .data_byte, .hashed_area, .first_of_signature, .last_of_area, .area_empty,
    .out_valid, .out_ready, .status, .found_mask, .creation_time,
    .signature_expiry, .key_expiry, .key_flag_bits, .issuer_key_id,
    .fingerprint_version, .embedded_offset, .embedded_length, .embedded_in_hashed
  );

  always #4 clk = ~clk;

  area_result_t pending_results[$];
  logic [7:0] area_bytes[$];
  int err_count = 0;
  int items_sent = 0;
  int cycles = 0;
  bit idle_on = 1;

  // parser model state
  logic [7:0]  m_sig_type = 0;
  phase_e      m_phase;
  logic [31:0] m_len_acc, m_idx, m_blen;
  logic [7:0]  m_type, m_first;
  logic [23:0] m_start, m_pos;
  logic [63:0] m_shift;
  logic [1:0]  m_err;
  logic [6:0]  m_found;
  logic [31:0] m_time, m_sexp, m_kexp, m_elen;
  logic [7:0]  m_flags;
  logic [63:0] m_kid;
  logic [2:0]  m_fpv;
  logic [23:0] m_eoff;
  logic        m_ehash;

  function void clear_parse();
    m_phase = P_LEN0; m_len_acc = 0; m_type = 0; m_idx = 0; m_blen = 0;
    m_first = 0; m_start = 0; m_shift = 0; m_pos = 0;
  endfunction

  function void clear_sig();
    clear_parse();
    m_err = ST_OK; m_found = 0; m_time = 0; m_sexp = 0; m_kexp = 0; m_flags = 0;
    m_kid = 0; m_fpv = 0; m_eoff = 0; m_elen = 0; m_ehash = 0;
  endfunction

  function void latch_err(logic [1:0] code);
    m_err = code;
    m_phase = P_SKIP;
  endfunction

  function bit fp_new_form();
    return m_first == 8'd5 || m_first == 8'd6;
  endfunction

  function void finish_subpacket(bit hashed);
    logic [6:0] t;
    logic [31:0] n;
    logic [6:0] bit_m;
    bit impl, ok;
    logic [1:0] e;
    t = m_type[6:0]; n = m_blen; impl = 0; e = ST_OK;
    case (t)
      SP_CREATION:
        if (hashed && n == 4) begin
          if (m_found & F_TIME) e = ST_DUP;
          else begin impl = 1; m_time = m_shift[31:0]; m_found |= F_TIME; end
        end
      SP_ISSUER:
        if (n == 8) begin
          impl = 1;
          if (!(m_found & F_ID)) begin m_kid = m_shift; m_found |= F_ID; end
        end
      SP_ISS_FP:
        if (n >= 17) begin
          ok = (m_first == 8'd4 && n == 21) || (fp_new_form() && n == 33);
          impl = 1;
          if (ok && !(m_found & F_FP)) begin m_fpv = m_first[2:0]; m_found |= F_FP; end
          if (ok && !(m_found & F_ID)) begin m_kid = m_shift; m_found |= F_ID; end
        end
      SP_FLAGS:
        if (hashed) begin
          if (m_found & F_FLAGS) e = ST_DUP;
          else begin impl = 1; m_flags = n >= 1 ? m_first : 8'd0; m_found |= F_FLAGS; end
        end
      SP_KEY_EXP, SP_SIG_EXP: begin
        bit_m = t == SP_KEY_EXP ? F_KEXP : F_SEXP;
        if (hashed && n == 4) begin
          if (m_found & bit_m) e = ST_DUP;
          else begin
            impl = 1;
            if (t == SP_KEY_EXP) m_kexp = m_shift[31:0];
            else m_sexp = m_shift[31:0];
            m_found |= bit_m;
          end
        end
      end
      SP_EMBEDDED:
        if (m_sig_type == SIG_SUBKEY_BINDING && n >= 6 && m_elen == 0) begin
          impl = 1; m_eoff = m_start; m_elen = n; m_ehash = hashed;
        end
      SP_PRIMARY:
        if (hashed && n == 1) begin
          impl = 1;
          if (m_first != 0) m_found |= F_PRIM;
        end
      default: ;
    endcase
    if (e == ST_OK && !impl && (m_type & CRIT_BIT)) e = ST_CRIT;
    if (e != ST_OK) latch_err(e);
    else m_phase = P_LEN0;
  endfunction

  function void parse_byte(logic [7:0] b, bit hashed);
    bit do_shift;
    case (m_phase)
      P_LEN0:
        if (b < LEN_TWO_MIN) begin
          if (b == 0) latch_err(ST_CORRUPT);
          else begin m_blen = 32'(b); m_phase = P_TYPE; end
        end else if (b < LEN_FIVE) begin
          m_len_acc = 32'(b); m_phase = P_LEN1;
        end else begin
          m_len_acc = 0; m_idx = 0; m_phase = P_LEN5;
        end
      P_LEN1: begin
        m_blen = (((m_len_acc - 32'd192) << 8) + b + 32'd192) & ((32'd1 << LB) - 32'd1);
        m_phase = P_TYPE;
      end
      P_LEN5: begin
        m_len_acc = (m_len_acc << 8) | b;
        m_idx++;
        if (m_idx >= 4) begin
          if ((m_len_acc >> LB) != 0 || m_len_acc == 0) latch_err(ST_CORRUPT);
          else begin m_blen = m_len_acc; m_phase = P_TYPE; end
        end
      end
      P_TYPE: begin
        m_type = b; m_blen = m_blen - 32'd1; m_idx = 0; m_first = 0; m_shift = 0;
        m_start = m_pos + 24'd1;
        if (m_blen == 0) finish_subpacket(hashed);
        else m_phase = P_BODY;
      end
      P_BODY: begin
        do_shift = 1;
        if (m_idx == 0) m_first = b;
        if (m_type[6:0] == SP_ISS_FP && fp_new_form()) do_shift = m_idx >= 1 && m_idx <= 8;
        if (do_shift) m_shift = (m_shift << 8) | b;
        m_idx++;
        if (m_idx >= m_blen) finish_subpacket(hashed);
      end
      default: ;
    endcase
  endfunction

  function void model_item(logic [7:0] b, bit hashed, bit first, bit last, bit empty);
    area_result_t r;
    if (first) clear_sig();
    if (!empty) begin
      if (m_err == ST_OK) parse_byte(b, hashed);
      m_pos = m_pos + 24'd1;
    end
    if (empty || last) begin
      if (m_err == ST_OK && m_phase != P_LEN0) m_err = ST_CORRUPT;
      r.status = m_err; r.found = m_found; r.ctime = m_time; r.sexp = m_sexp;
      r.kexp = m_kexp; r.flags = m_flags; r.key_id = m_kid; r.fp_ver = m_fpv;
      r.emb_off = m_eoff; r.emb_len = m_elen[23:0]; r.emb_hashed = m_ehash;
      pending_results.push_back(r);
      clear_parse();
    end
  endfunction

  initial clear_sig();

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver back-pressure
  always @(negedge clk) out_ready <= !idle_on || ($urandom_range(99) >= 23);

  function void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      err_count++;
    end
  endfunction

  always @(posedge clk) begin
    area_result_t r;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing expected");
        err_count++;
      end else begin
        r = pending_results.pop_front();
        check_field("status", r.status, status);
        check_field("found_mask", r.found, found_mask);
        check_field("creation_time", r.ctime, creation_time);
        check_field("signature_expiry", r.sexp, signature_expiry);
        check_field("key_expiry", r.kexp, key_expiry);
        check_field("key_flag_bits", r.flags, key_flag_bits);
        check_field("issuer_key_id", r.key_id, issuer_key_id);
        check_field("fingerprint_version", r.fp_ver, fingerprint_version);
        check_field("embedded_offset", r.emb_off, embedded_offset);
        check_field("embedded_length", r.emb_len, embedded_length);
        check_field("embedded_in_hashed", r.emb_hashed, embedded_in_hashed);
      end
    end
  end

  task send_item(logic [7:0] b, bit hashed, bit first, bit last, bit empty);
    @(negedge clk);
    while (idle_on && $urandom_range(99) < 23) begin
      in_valid = 0;
      @(negedge clk);
    end
    data_byte = b; hashed_area = hashed; first_of_signature = first;
    last_of_area = last; area_empty = empty; in_valid = 1;
    do @(posedge clk); while (!in_ready);
    model_item(b, hashed, first, last, empty);
    items_sent++;
  endtask

  task stop_input();
    @(negedge clk);
    in_valid = 0;
  endtask

  task wait_drained();
    stop_input();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task write_sig_type(logic [7:0] v);
    wait_drained();
    repeat (8) @(posedge clk);
    @(negedge clk);
    cfg_we = 1; cfg_wdata = v;
    m_sig_type = v;
    @(negedge clk);
    cfg_we = 0;
  endtask

  // sends area_bytes as one area; an empty queue goes as an empty-area item
  task send_area(bit hashed, bit first);
    int n;
    n = area_bytes.size();
    if (n == 0)
      send_item(8'($urandom_range(255)), hashed, first, 1'($urandom_range(1)), 1);
    for (int i = 0; i < n; i++)
      send_item(area_bytes[i], ($urandom_range(9) == 0) ? !hashed : hashed,
                first && i == 0, i == n - 1, 0);
    area_bytes.delete();
  endtask

  function void put_bytes(int n, logic [7:0] v0 = 0, bit rnd = 1);
    for (int i = 0; i < n; i++) area_bytes.push_back(rnd ? 8'($urandom_range(255)) : v0);
  endfunction

  // one subpacket: length (1, 2 or 5 octets), type, body
  function void add_subpacket(logic [7:0] t, int body_len, logic [7:0] first_b, bit five);
    int l;
    l = body_len + 1;
    if (five || l >= 8384) begin
      area_bytes.push_back(LEN_FIVE);
      for (int s = 24; s >= 0; s -= 8) area_bytes.push_back(8'(l >> s));
    end else if (l >= 192) begin
      area_bytes.push_back(8'(((l - 192) >> 8) + 192));
      area_bytes.push_back(8'(l - 192));
    end else area_bytes.push_back(8'(l));
    area_bytes.push_back(t);
    if (body_len > 0) begin
      area_bytes.push_back(first_b);
      put_bytes(body_len - 1);
    end
  endfunction

  function void add_random_subpacket();
    logic [7:0] t, crit, fb;
    int n;
    crit = ($urandom_range(5) == 0) ? CRIT_BIT : 8'h00;
    fb = 8'($urandom_range(255));
    case ($urandom_range(9))
      0: begin t = SP_CREATION; n = 4; end
      1: begin t = SP_SIG_EXP; n = 4; end
      2: begin t = SP_KEY_EXP; n = 4; end
      3: begin t = SP_ISSUER; n = 8; end
      4: begin
        t = SP_ISS_FP; fb = 8'($urandom_range(4, 6));
        n = (fb == 4) ? 21 : 33;
        if ($urandom_range(4) == 0) n = $urandom_range(16, 34);
      end
      5: begin t = SP_FLAGS; n = $urandom_range(3); end
      6: begin t = SP_PRIMARY; n = 1; fb = 8'($urandom_range(1)); end
      7: begin t = SP_EMBEDDED; n = ($urandom_range(15) == 0) ? 200 : $urandom_range(4, 12); end
      8: begin t = 8'($urandom_range(127)); n = $urandom_range(6); end
      default: begin
        t = $urandom_range(1) ? SP_CREATION : SP_ISSUER; n = $urandom_range(10);
      end
    endcase
    add_subpacket(t | crit, n, fb, $urandom_range(9) == 0);
  endfunction

  function void build_random_area();
    int k;
    k = $urandom_range(4);
    for (int i = 0; i < k; i++) add_random_subpacket();
    case ($urandom_range(19))
      0: put_bytes($urandom_range(1, 3));
      1: if (area_bytes.size() > 0) void'(area_bytes.pop_back());
      2: area_bytes.push_back(8'h00);
      3: begin area_bytes.push_back(LEN_FIVE); put_bytes(4, 8'h01, 0); end
      default: ;
    endcase
  endfunction

  task test_directed();
    write_sig_type(SIG_SUBKEY_BINDING);
    add_subpacket(SP_CREATION, 4, 8'hde, 0);
    add_subpacket(SP_FLAGS, 1, 8'hff, 0);
    add_subpacket(SP_PRIMARY, 1, 8'h01, 0);
    send_area(1, 1);
    add_subpacket(SP_ISSUER, 8, 8'h00, 0);
    add_subpacket(SP_EMBEDDED, 6, 8'h04, 0);
    send_area(0, 0);
    send_area(1, 1);                               // empty area
    area_bytes.push_back(8'h00);                   // zero length
    send_area(1, 1);
    add_subpacket(8'h64 | CRIT_BIT, 1, 8'h00, 0);  // unknown critical
    send_area(1, 1);
    area_bytes.push_back(LEN_FIVE);                // five-octet length too large
    put_bytes(1, 8'h01, 0); put_bytes(3, 8'h00, 0);
    send_area(1, 1);
    area_bytes.push_back(8'h05); area_bytes.push_back(8'h02);  // truncated
    send_area(1, 1);
    send_area(1, 0);                               // error held into next area
    add_subpacket(SP_CREATION, 4, 8'h00, 1);
    add_subpacket(SP_CREATION, 4, 8'hff, 0);       // duplicate
    send_area(1, 1);
  endtask

  task test_random(int n_items);
    int stop_at;
    bit first;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      first = $urandom_range(5) != 0;
      build_random_area();
      send_area(1, first);
      build_random_area();
      send_area(0, 0);
      if ($urandom_range(29) == 0) wait_drained();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 0;
    test_directed();
    write_sig_type(SIG_SUBKEY_BINDING);
    test_random(160);
    wait_drained();                     // sender holds off until all results are in
    idle_on = 0;
    test_random(80);
    idle_on = 1;
    write_sig_type(8'hff);
    test_random(80);
    write_sig_type(8'($urandom_range(255)));
    test_random(60);
    write_sig_type(8'h00);
    test_random(60);
    wait_drained();
    repeat (20) @(posedge clk);
    if (err_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: signature_subpacket_parser_unit.f
hdl/sspu_pkg.sv
hdl/sspu_front.sv
hdl/sspu_back.sv
hdl/signature_subpacket_parser_unit.sv
tb/tb_signature_subpacket_parser_unit.sv
